// ===== sv/cpts_pkg.sv =====
`default_nettype none

package cpts_pkg;

	localparam int MAX_TASKS_DEF     = 64;
	localparam int PRIORITY_BITS_DEF = 8;
	localparam int COUNTER_BITS_DEF  = 11;

	localparam int DEPTH_W = 8;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'hFF;

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_YIELD  = 3'd1;
	localparam logic [2:0] CMD_ADD    = 3'd2;
	localparam logic [2:0] CMD_SETRUN = 3'd3;
	localparam logic [2:0] CMD_PDIS   = 3'd4;
	localparam logic [2:0] CMD_PEN    = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	localparam logic OP_DEC  = 1'b0;
	localparam logic OP_RECH = 1'b1;

	typedef struct packed {
		logic [2:0] command;
		logic [5:0] task_slot;
		logic [7:0] new_priority;
		logic       runnable;
	} item_t;

	typedef struct packed {
		logic [5:0] current_task;
		logic       switched;
		logic [5:0] added_slot;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic ctr_we;
		logic prio_we;
		logic dep_we;
		logic add_en;
		logic setrun_en;
		logic run_val;
	} tbl_ctl_t;

endpackage

`default_nettype wire

// ===== sv/counter_priority_task_scheduler_core.sv =====
// Task scheduler with per-task time-slice counters recharged from priorities. One command
// is taken per transfer on the item channel and answered by one transfer on the result
// channel; item_stall stays high while a command is in work. Add, set-runnable, unused
// codes and preempt commands finish without a scan. A tick or yield that schedules runs one
// or more passes over the counter memory through a single read port and one shared
// saturating add/compare unit: a pick pass, and when the largest runnable counter is zero a
// recharge pass and a second pick pass. The result register lets the next command be taken
// while a result still waits.
`default_nettype none

module counter_priority_task_scheduler_core #(
	parameter int MAX_TASKS     = cpts_pkg::MAX_TASKS_DEF,
	parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF,
	parameter int COUNTER_BITS  = cpts_pkg::COUNTER_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire cpts_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output cpts_pkg::result_t      result
);

	localparam int IDXW = $clog2(MAX_TASKS);
	localparam int CNTW = $clog2(MAX_TASKS + 1);
	localparam int PB   = PRIORITY_BITS;
	localparam int CB   = COUNTER_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_RECH = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]         state_q;
	logic [2:0]         cmd_q;
	logic [IDXW-1:0]    before_q;
	logic [IDXW-1:0]    run_idx_q;
	logic [CNTW-1:0]    count_q;
	logic [IDXW-1:0]    added_q;
	logic [1:0]         status_q;
	logic [CNTW-1:0]    idx_q;
	logic               pend_s1;
	logic [IDXW-1:0]    pidx_s1;
	logic signed [CB-1:0] best_q;
	logic [IDXW-1:0]    sel_q;
	logic               rech_q;
	cpts_pkg::result_t  result_q;
	logic               result_valid_q;

	cpts_pkg::tbl_ctl_t          ctl;
	logic [IDXW-1:0]             waddr;
	logic [IDXW-1:0]             raddr;
	logic signed [CB-1:0]        ctr_wd;
	logic [cpts_pkg::DEPTH_W-1:0] dep_wd;
	logic signed [CB-1:0]        rd_ctr;
	logic [PB-1:0]               rd_prio;
	logic [cpts_pkg::DEPTH_W-1:0] rd_dep;
	logic [MAX_TASKS-1:0]        present;
	logic [MAX_TASKS-1:0]        runnable;

	logic                 alu_op;
	logic signed [CB-1:0] alu_a;
	logic [PB-1:0]        alu_prio;
	logic signed [CB-1:0] alu_res;
	logic                 alu_gt;

	logic                 accept;
	logic [PB+7:0]        prio_w;
	logic [PB-1:0]        item_prio;
	logic [IDXW+5:0]      slot_w;
	logic [IDXW-1:0]      slot_idx;
	logic                 slot_ok;
	logic                 full;
	logic [IDXW-1:0]      count_idx;
	logic                 sched_tick;
	logic                 scan_issue;
	logic                 scan_end;
	logic                 cand;
	logic [IDXW+5:0]      cur_w;
	logic [IDXW+5:0]      add_w;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);

	assign prio_w    = {{PB{1'b0}}, item.new_priority};
	assign item_prio = prio_w[PB-1:0];
	assign slot_w    = {{IDXW{1'b0}}, item.task_slot};
	assign slot_idx  = slot_w[IDXW-1:0];
	assign slot_ok   = (32'(item.task_slot) < MAX_TASKS) && present[slot_idx];
	assign full      = (count_q == CNTW'(MAX_TASKS));
	assign count_idx = count_q[IDXW-1:0];

	assign sched_tick = ((alu_res[CB-1] == 1'b1) || (alu_res == '0)) && (rd_dep == '0);
	assign scan_issue = (idx_q < CNTW'(MAX_TASKS));
	assign scan_end   = !scan_issue && !pend_s1;
	assign cand       = pend_s1 && present[pidx_s1] && runnable[pidx_s1] && alu_gt;

	cpts_table #(
		.MAX_TASKS    (MAX_TASKS),
		.PRIORITY_BITS(PRIORITY_BITS),
		.COUNTER_BITS (COUNTER_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.waddr   (waddr),
		.ctr_wd  (ctr_wd),
		.prio_wd (item_prio),
		.dep_wd  (dep_wd),
		.raddr   (raddr),
		.rd_ctr  (rd_ctr),
		.rd_prio (rd_prio),
		.rd_dep  (rd_dep),
		.present (present),
		.runnable(runnable)
	);

	cpts_alu #(
		.PRIORITY_BITS(PRIORITY_BITS),
		.COUNTER_BITS (COUNTER_BITS)
	) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (best_q),
		.prio(alu_prio),
		.res (alu_res),
		.gt  (alu_gt)
	);

	always_comb begin
		ctl         = '0;
		ctl.run_val = item.runnable;
		waddr       = run_idx_q;
		raddr       = run_idx_q;
		ctr_wd      = '0;
		dep_wd      = rd_dep;
		alu_op      = cpts_pkg::OP_RECH;
		alu_a       = rd_ctr;
		alu_prio    = rd_prio;
		case (state_q)
			S_IDLE: begin
				alu_a    = '0;
				alu_prio = item_prio;
				if (accept) begin
					case (item.command)
						cpts_pkg::CMD_YIELD: begin
							ctl.ctr_we = 1'b1;
						end
						cpts_pkg::CMD_ADD: begin
							if (!full) begin
								waddr       = count_idx;
								ctl.ctr_we  = 1'b1;
								ctl.prio_we = 1'b1;
								ctl.dep_we  = 1'b1;
								ctl.add_en  = 1'b1;
								ctr_wd      = alu_res;
								dep_wd      = '0;
							end
						end
						cpts_pkg::CMD_SETRUN: begin
							if (slot_ok) begin
								waddr         = slot_idx;
								ctl.setrun_en = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_EXEC: begin
				alu_op = cpts_pkg::OP_DEC;
				case (cmd_q)
					cpts_pkg::CMD_TICK: begin
						ctl.ctr_we = 1'b1;
						ctr_wd     = sched_tick ? '0 : alu_res;
					end
					cpts_pkg::CMD_PDIS: begin
						ctl.dep_we = 1'b1;
						dep_wd     = (rd_dep == cpts_pkg::DEPTH_MAX) ? rd_dep : rd_dep + 1'b1;
					end
					cpts_pkg::CMD_PEN: begin
						ctl.dep_we = 1'b1;
						dep_wd     = (rd_dep == '0) ? rd_dep : rd_dep - 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				raddr = idx_q[IDXW-1:0];
			end
			S_RECH: begin
				raddr  = idx_q[IDXW-1:0];
				waddr  = pidx_s1;
				ctr_wd = alu_res;
				if (pend_s1 && present[pidx_s1]) begin
					ctl.ctr_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cur_w = {6'b0, run_idx_q};
	assign add_w = {6'b0, added_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cmd_q          <= cpts_pkg::CMD_TICK;
			before_q       <= '0;
			run_idx_q      <= '0;
			count_q        <= CNTW'(1);
			added_q        <= '0;
			status_q       <= cpts_pkg::ST_OK;
			idx_q          <= '0;
			pend_s1        <= 1'b0;
			pidx_s1        <= '0;
			best_q         <= '1;
			sel_q          <= '0;
			rech_q         <= 1'b0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != S_OUT) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= item.command;
						before_q <= run_idx_q;
						case (item.command)
							cpts_pkg::CMD_TICK, cpts_pkg::CMD_PDIS, cpts_pkg::CMD_PEN: begin
								status_q <= cpts_pkg::ST_OK;
								added_q  <= '0;
								state_q  <= S_EXEC;
							end
							cpts_pkg::CMD_YIELD: begin
								status_q <= cpts_pkg::ST_OK;
								added_q  <= '0;
								idx_q    <= '0;
								pend_s1  <= 1'b0;
								best_q   <= '1;
								sel_q    <= '0;
								rech_q   <= 1'b0;
								state_q  <= S_SCAN;
							end
							cpts_pkg::CMD_ADD: begin
								if (full) begin
									status_q <= cpts_pkg::ST_FULL;
									added_q  <= '0;
								end else begin
									status_q <= cpts_pkg::ST_OK;
									added_q  <= count_idx;
									count_q  <= count_q + 1'b1;
								end
								state_q <= S_OUT;
							end
							cpts_pkg::CMD_SETRUN: begin
								status_q <= slot_ok ? cpts_pkg::ST_OK : cpts_pkg::ST_ABSENT;
								added_q  <= '0;
								state_q  <= S_OUT;
							end
							default: begin
								status_q <= cpts_pkg::ST_OK;
								added_q  <= '0;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_EXEC: begin
					if (cmd_q == cpts_pkg::CMD_TICK && sched_tick) begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						best_q  <= '1;
						sel_q   <= '0;
						rech_q  <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SCAN: begin
					pend_s1 <= scan_issue;
					if (scan_issue) begin
						idx_q   <= idx_q + 1'b1;
						pidx_s1 <= idx_q[IDXW-1:0];
					end
					if (cand) begin
						best_q <= rd_ctr;
						sel_q  <= pidx_s1;
					end
					if (scan_end) begin
						if (best_q == '0 && !rech_q) begin
							idx_q   <= '0;
							rech_q  <= 1'b1;
							state_q <= S_RECH;
						end else begin
							run_idx_q <= sel_q;
							state_q   <= S_OUT;
						end
					end
				end
				S_RECH: begin
					pend_s1 <= scan_issue;
					if (scan_issue) begin
						idx_q   <= idx_q + 1'b1;
						pidx_s1 <= idx_q[IDXW-1:0];
					end
					if (scan_end) begin
						idx_q   <= '0;
						best_q  <= '1;
						sel_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.current_task <= cur_w[5:0];
						result_q.switched     <= (run_idx_q != before_q);
						result_q.added_slot   <= add_w[5:0];
						result_q.status       <= status_q;
						result_valid_q        <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

`ifndef SYNTHESIS
	a_run_present: assert property (@(posedge clk) disable iff (!arst_n)
		present[run_idx_q])
		else $error("running task not present");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CNTW'(MAX_TASKS))
		else $error("task count out of range");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside output state");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_RECH) |-> idx_q <= CNTW'(MAX_TASKS))
		else $error("scan index overran table");
`endif

endmodule

`default_nettype wire

// ===== sv/cpts_alu.sv =====
`default_nettype none

module cpts_alu #(
	parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF,
	parameter int COUNTER_BITS  = cpts_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                            op,
	input  wire logic signed [COUNTER_BITS-1:0]  a,
	input  wire logic signed [COUNTER_BITS-1:0]  b,
	input  wire logic        [PRIORITY_BITS-1:0] prio,
	output logic signed      [COUNTER_BITS-1:0]  res,
	output logic                                 gt
);

	localparam int CB = COUNTER_BITS;
	localparam int PB = PRIORITY_BITS;
	localparam int SW = ((CB > PB + 1) ? CB : PB + 1) + 1;
	localparam logic signed [SW-1:0] MAXV = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}};

	logic signed [SW-1:0] base;
	logic signed [SW-1:0] addend;
	logic signed [SW-1:0] sum;

	// recharge: floor(a/2) + prio; decrement: a - 1; both saturate
	always_comb begin
		if (op == cpts_pkg::OP_RECH) begin
			base   = SW'(a >>> 1);
			addend = $signed({{(SW-PB){1'b0}}, prio});
		end else begin
			base   = SW'(a);
			addend = '1;
		end
		sum = base + addend;
		if (sum > MAXV) begin
			res = MAXV[CB-1:0];
		end else if (sum < MINV) begin
			res = MINV[CB-1:0];
		end else begin
			res = sum[CB-1:0];
		end
	end

	assign gt = a > b;

endmodule

`default_nettype wire

// ===== sv/cpts_table.sv =====
`default_nettype none

module cpts_table #(
	parameter int MAX_TASKS     = cpts_pkg::MAX_TASKS_DEF,
	parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF,
	parameter int COUNTER_BITS  = cpts_pkg::COUNTER_BITS_DEF,
	localparam int IDXW = $clog2(MAX_TASKS)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cpts_pkg::tbl_ctl_t                  ctl,
	input  wire logic        [IDXW-1:0]              waddr,
	input  wire logic signed [COUNTER_BITS-1:0]      ctr_wd,
	input  wire logic        [PRIORITY_BITS-1:0]     prio_wd,
	input  wire logic        [cpts_pkg::DEPTH_W-1:0] dep_wd,
	input  wire logic        [IDXW-1:0]              raddr,
	output logic signed      [COUNTER_BITS-1:0]      rd_ctr,
	output logic             [PRIORITY_BITS-1:0]     rd_prio,
	output logic             [cpts_pkg::DEPTH_W-1:0] rd_dep,
	output logic             [MAX_TASKS-1:0]         present,
	output logic             [MAX_TASKS-1:0]         runnable
);

	logic [COUNTER_BITS-1:0]      ctr_mem  [MAX_TASKS];
	logic [PRIORITY_BITS-1:0]     prio_mem [MAX_TASKS];
	logic [cpts_pkg::DEPTH_W-1:0] dep_mem  [MAX_TASKS];

	logic [COUNTER_BITS-1:0]      ctr_rd_q;
	logic [PRIORITY_BITS-1:0]     prio_rd_q;
	logic [cpts_pkg::DEPTH_W-1:0] dep_rd_q;

	// per-entry written marks; unwritten entries read as reset values
	logic [MAX_TASKS-1:0] ctr_vld_q;
	logic [MAX_TASKS-1:0] prio_vld_q;
	logic [MAX_TASKS-1:0] dep_vld_q;
	logic                 ctr_rv_q;
	logic                 prio_rv_q;
	logic                 dep_rv_q;
	logic                 rzero_q;
	logic [MAX_TASKS-1:0] present_q;
	logic [MAX_TASKS-1:0] runnable_q;

	always_ff @(posedge clk) begin
		if (ctl.ctr_we) begin
			ctr_mem[waddr] <= ctr_wd;
		end
		if (ctl.prio_we) begin
			prio_mem[waddr] <= prio_wd;
		end
		if (ctl.dep_we) begin
			dep_mem[waddr] <= dep_wd;
		end
		ctr_rd_q  <= ctr_mem[raddr];
		prio_rd_q <= prio_mem[raddr];
		dep_rd_q  <= dep_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_vld_q  <= '0;
			prio_vld_q <= '0;
			dep_vld_q  <= '0;
			ctr_rv_q   <= 1'b0;
			prio_rv_q  <= 1'b0;
			dep_rv_q   <= 1'b0;
			rzero_q    <= 1'b0;
			present_q  <= MAX_TASKS'(1);
			runnable_q <= MAX_TASKS'(1);
		end else begin
			if (ctl.ctr_we) begin
				ctr_vld_q[waddr] <= 1'b1;
			end
			if (ctl.prio_we) begin
				prio_vld_q[waddr] <= 1'b1;
			end
			if (ctl.dep_we) begin
				dep_vld_q[waddr] <= 1'b1;
			end
			if (ctl.add_en) begin
				present_q[waddr]  <= 1'b1;
				runnable_q[waddr] <= ctl.run_val;
			end
			if (ctl.setrun_en) begin
				runnable_q[waddr] <= ctl.run_val;
			end
			ctr_rv_q  <= ctr_vld_q[raddr];
			prio_rv_q <= prio_vld_q[raddr];
			dep_rv_q  <= dep_vld_q[raddr];
			rzero_q   <= (raddr == '0);
		end
	end

	assign rd_ctr   = ctr_rv_q ? $signed(ctr_rd_q) : '0;
	assign rd_prio  = prio_rv_q ? prio_rd_q : PRIORITY_BITS'(rzero_q);
	assign rd_dep   = dep_rv_q ? dep_rd_q : '0;
	assign present  = present_q;
	assign runnable = runnable_q;

endmodule

`default_nettype wire
